// ===== src/eulxyz_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler x-y-z rotate block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package eulxyz_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_WIDTH  = 16;
  localparam int TRIG_W       = 32;
  localparam int ROT_W        = COORD_WIDTH + 4;
  localparam int PROD_W       = ROT_W + TRIG_W;
  localparam int HORNER_SLOTS = 9;
  localparam int SC_STAGES    = 3 * HORNER_SLOTS + 5;
  localparam int NUM_STAGES   = SC_STAGES + 8;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ANGLE_WIDTH-1:0]        angle_t;
  typedef logic signed [TRIG_W-1:0]      trig_t;
  typedef logic signed [ROT_W-1:0]       wide_t;

  localparam wide_t COORD_MAX_W = wide_t'((longint'(1) << (COORD_WIDTH - 1)) - 1);
  localparam wide_t COORD_MIN_W = wide_t'(-(longint'(1) << (COORD_WIDTH - 1)));

  typedef struct packed {
    coord_t vec_x;
    coord_t vec_y;
    coord_t vec_z;
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;
    coord_t offset_d;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
  } out_item_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  function automatic longint horner_div(int slot, bit odd);
    longint k;
    k = longint'(HORNER_SLOTS - slot);
    horner_div = odd ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
  endfunction

  // a * t / 2^30, rounded to nearest, ties away from zero
  function automatic wide_t mul_q30(wide_t a, trig_t t);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] bias;
    p    = PROD_W'(a) * PROD_W'(t);
    bias = p[PROD_W-1] ? PROD_W'((1 << 29) - 1) : PROD_W'(1 << 29);
    mul_q30 = ROT_W'((p + bias) >>> 30);
  endfunction

  function automatic coord_t sat_coord(wide_t v);
    if (v > COORD_MAX_W) begin
      sat_coord = COORD_WIDTH'(COORD_MAX_W);
    end else if (v < COORD_MIN_W) begin
      sat_coord = COORD_WIDTH'(COORD_MIN_W);
    end else begin
      sat_coord = COORD_WIDTH'(v);
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/eulxyz_sincos.sv =====
// Pipelined sine/cosine of a binary-fraction angle: quadrant split, Q1.30 radians,
// Horner series evaluation one term per three stages. Depends on eulxyz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eulxyz_sincos (
  input  logic                                 clk,
  input  logic [eulxyz_pkg::SC_STAGES-1:0]     ld,
  input  eulxyz_pkg::angle_t                   angle,
  output eulxyz_pkg::trig_t                    sin_o,
  output eulxyz_pkg::trig_t                    cos_o
);
  import eulxyz_pkg::*;

  localparam int LOW_W = ANGLE_WIDTH - 2;
  localparam int PA_W  = LOW_W + 31;

  typedef struct packed {
    quad_t       quad;
    logic [30:0] u;
    logic [31:0] u2;
  } carry_t;

  logic [PA_W-1:0] prod_a_r;
  quad_t           quad_a_r;
  logic [30:0]     u_b_r;
  quad_t           quad_b_r;
  carry_t          carry0_r;
  logic [62:0]     ua_full;
  logic [62:0]     u2_full;
  carry_t          carry [HORNER_SLOTS+1];
  logic [30:0]     s_chain [2][HORNER_SLOTS+1];
  logic [62:0]     sin_full;
  logic [30:0]     sin_r;
  logic [30:0]     cos_r;
  quad_t           quad_f_r;
  trig_t           sin_r2;
  trig_t           cos_r2;

  always_comb begin
    ua_full  = (63'(prod_a_r) << (32 - ANGLE_WIDTH)) + 63'(Q30_ONE >> 1);
    u2_full  = 63'(u_b_r) * 63'(u_b_r) + 63'(Q30_ONE >> 1);
    sin_full = 63'(carry[HORNER_SLOTS].u) * 63'(s_chain[1][HORNER_SLOTS]) + 63'(Q30_ONE >> 1);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      prod_a_r <= PA_W'(angle[LOW_W-1:0]) * PA_W'(HALF_PI_Q30);
      quad_a_r <= quad_t'(angle[ANGLE_WIDTH-1 -: 2]);
    end
    if (ld[1]) begin
      u_b_r    <= 31'(ua_full >> 30);
      quad_b_r <= quad_a_r;
    end
    if (ld[2]) begin
      carry0_r.quad <= quad_b_r;
      carry0_r.u    <= u_b_r;
      carry0_r.u2   <= 32'(u2_full >> 30);
    end
  end

  assign carry[0]      = carry0_r;
  assign s_chain[0][0] = Q30_ONE;
  assign s_chain[1][0] = Q30_ONE;

  for (genvar j = 0; j < HORNER_SLOTS; j++) begin : g_slot
    carry_t c1_r;
    carry_t c2_r;
    carry_t c3_r;

    always_ff @(posedge clk) begin
      if (ld[3 + 3 * j]) c1_r <= carry[j];
      if (ld[4 + 3 * j]) c2_r <= c1_r;
      if (ld[5 + 3 * j]) c3_r <= c2_r;
    end

    assign carry[j+1] = c3_r;

    for (genvar c = 0; c < 2; c++) begin : g_chain
      if (c == 0 || j > 0) begin : g_step
        localparam longint D = horner_div(j, c == 1);
        localparam longint M = (longint'(1) << 33) / D;

        logic [31:0] p_r;
        logic [32:0] n_r;
        logic [31:0] q_r;
        logic [30:0] s_r;
        logic [63:0] p_full;
        logic [32:0] n;
        logic [65:0] qm;
        logic [32:0] rem;
        logic [31:0] q_fix;

        always_comb begin
          p_full = 64'(carry[j].u2) * 64'(s_chain[c][j]) + 64'(Q30_ONE >> 1);
          n      = 33'(p_r) + 33'(D / 2);
          qm     = 66'(n) * 66'(M);
          rem    = n_r - 33'(64'(q_r) * 64'(D));
          q_fix  = (rem >= 33'(D)) ? q_r + 32'd1 : q_r;
        end

        always_ff @(posedge clk) begin
          if (ld[3 + 3 * j]) p_r <= 32'(p_full >> 30);
          if (ld[4 + 3 * j]) begin
            n_r <= n;
            q_r <= 32'(qm >> 33);
          end
          if (ld[5 + 3 * j]) s_r <= Q30_ONE - 31'(q_fix);
        end

        assign s_chain[c][j+1] = s_r;
      end else begin : g_one
        assign s_chain[c][j+1] = Q30_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[SC_STAGES-2]) begin
      sin_r    <= 31'(sin_full >> 30);
      cos_r    <= s_chain[0][HORNER_SLOTS];
      quad_f_r <= carry[HORNER_SLOTS].quad;
    end
    if (ld[SC_STAGES-1]) begin
      unique case (quad_f_r)
        QUAD_0: begin
          sin_r2 <= trig_t'({1'b0, sin_r});
          cos_r2 <= trig_t'({1'b0, cos_r});
        end
        QUAD_1: begin
          sin_r2 <= trig_t'({1'b0, cos_r});
          cos_r2 <= -trig_t'({1'b0, sin_r});
        end
        QUAD_2: begin
          sin_r2 <= -trig_t'({1'b0, sin_r});
          cos_r2 <= -trig_t'({1'b0, cos_r});
        end
        QUAD_3: begin
          sin_r2 <= -trig_t'({1'b0, cos_r});
          cos_r2 <= trig_t'({1'b0, sin_r});
        end
        default: begin
          sin_r2 <= '0;
          cos_r2 <= '0;
        end
      endcase
    end
  end

  assign sin_o = sin_r2;
  assign cos_o = cos_r2;

endmodule

`default_nettype wire

// ===== src/euler_xyz_rotate_translate_top.sv =====
// Top level: rotates a Q16.16 point about x, y, then z and adds an offset to x.
// Depends on eulxyz_pkg and eulxyz_sincos.
//
// One point enters per clock while in_ready is high; it passes through NUM_STAGES
// (40) register stages: one input stage, 32 stages of sine/cosine evaluation (the
// nine-term series, three stages per term, sets that depth), six rotation stages
// and the saturating output register. Stages hold independent valid bits; a
// stalled output only stops the stages behind it that are full, so empty stages
// keep filling and in_ready stays high while any bubble remains.
`timescale 1ns / 1ps
`default_nettype none

module euler_xyz_rotate_translate_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  eulxyz_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output eulxyz_pkg::out_item_t out_data
);
  import eulxyz_pkg::*;

  localparam int RX_MUL = SC_STAGES + 1;
  localparam int RX_ADD = SC_STAGES + 2;
  localparam int RY_MUL = SC_STAGES + 3;
  localparam int RY_ADD = SC_STAGES + 4;
  localparam int RZ_MUL = SC_STAGES + 5;
  localparam int RZ_ADD = SC_STAGES + 6;
  localparam int OUT_ST = SC_STAGES + 7;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t d;
  } pt_t;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] ld;
  in_item_t              in_r;
  pt_t                   pt_r [1:SC_STAGES];
  trig_t                 sx, cx, sy, cy, sz, cz;

  wide_t rx_yc_r, rx_zs_r, rx_ys_r, rx_zc_r;
  wide_t rx_x_r, rx_d_r;
  trig_t rx_sy_r, rx_cy_r, rx_sz_r, rx_cz_r;

  wide_t ra_x_r, ra_y_r, ra_z_r, ra_d_r;
  trig_t ra_sy_r, ra_cy_r, ra_sz_r, ra_cz_r;

  wide_t ry_xc_r, ry_zs_r, ry_zc_r, ry_xs_r;
  wide_t ry_y_r, ry_d_r;
  trig_t ry_sz_r, ry_cz_r;

  wide_t rb_x_r, rb_y_r, rb_z_r, rb_d_r;
  trig_t rb_sz_r, rb_cz_r;

  wide_t rz_xc_r, rz_ys_r, rz_yc_r, rz_xs_r;
  wide_t rz_z_r, rz_d_r;

  wide_t rc_x_r, rc_y_r, rc_z_r, rc_d_r;

  out_item_t out_r;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_ld
    assign ld[i] = out_ready | ~(&v_r[NUM_STAGES-1:i]);
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[OUT_ST];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ld[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) in_r <= in_data;
    if (ld[1]) pt_r[1] <= '{x: in_r.vec_x, y: in_r.vec_y, z: in_r.vec_z, d: in_r.offset_d};
    for (int k = 2; k <= SC_STAGES; k++) begin
      if (ld[k]) pt_r[k] <= pt_r[k-1];
    end
  end

  eulxyz_sincos u_trig_x (
    .clk   (clk),
    .ld    (ld[SC_STAGES:1]),
    .angle (in_r.angle_x),
    .sin_o (sx),
    .cos_o (cx)
  );

  eulxyz_sincos u_trig_y (
    .clk   (clk),
    .ld    (ld[SC_STAGES:1]),
    .angle (in_r.angle_y),
    .sin_o (sy),
    .cos_o (cy)
  );

  eulxyz_sincos u_trig_z (
    .clk   (clk),
    .ld    (ld[SC_STAGES:1]),
    .angle (in_r.angle_z),
    .sin_o (sz),
    .cos_o (cz)
  );

  always_ff @(posedge clk) begin
    if (ld[RX_MUL]) begin
      rx_yc_r <= mul_q30(wide_t'(pt_r[SC_STAGES].y), cx);
      rx_zs_r <= mul_q30(wide_t'(pt_r[SC_STAGES].z), sx);
      rx_ys_r <= mul_q30(wide_t'(pt_r[SC_STAGES].y), sx);
      rx_zc_r <= mul_q30(wide_t'(pt_r[SC_STAGES].z), cx);
      rx_x_r  <= wide_t'(pt_r[SC_STAGES].x);
      rx_d_r  <= wide_t'(pt_r[SC_STAGES].d);
      rx_sy_r <= sy;
      rx_cy_r <= cy;
      rx_sz_r <= sz;
      rx_cz_r <= cz;
    end
    if (ld[RX_ADD]) begin
      ra_x_r  <= rx_x_r;
      ra_y_r  <= rx_yc_r - rx_zs_r;
      ra_z_r  <= rx_ys_r + rx_zc_r;
      ra_d_r  <= rx_d_r;
      ra_sy_r <= rx_sy_r;
      ra_cy_r <= rx_cy_r;
      ra_sz_r <= rx_sz_r;
      ra_cz_r <= rx_cz_r;
    end
    if (ld[RY_MUL]) begin
      ry_xc_r <= mul_q30(ra_x_r, ra_cy_r);
      ry_zs_r <= mul_q30(ra_z_r, ra_sy_r);
      ry_zc_r <= mul_q30(ra_z_r, ra_cy_r);
      ry_xs_r <= mul_q30(ra_x_r, ra_sy_r);
      ry_y_r  <= ra_y_r;
      ry_d_r  <= ra_d_r;
      ry_sz_r <= ra_sz_r;
      ry_cz_r <= ra_cz_r;
    end
    if (ld[RY_ADD]) begin
      rb_x_r  <= ry_xc_r + ry_zs_r;
      rb_y_r  <= ry_y_r;
      rb_z_r  <= ry_zc_r - ry_xs_r;
      rb_d_r  <= ry_d_r;
      rb_sz_r <= ry_sz_r;
      rb_cz_r <= ry_cz_r;
    end
    if (ld[RZ_MUL]) begin
      rz_xc_r <= mul_q30(rb_x_r, rb_cz_r);
      rz_ys_r <= mul_q30(rb_y_r, rb_sz_r);
      rz_yc_r <= mul_q30(rb_y_r, rb_cz_r);
      rz_xs_r <= mul_q30(rb_x_r, rb_sz_r);
      rz_z_r  <= rb_z_r;
      rz_d_r  <= rb_d_r;
    end
    if (ld[RZ_ADD]) begin
      rc_x_r <= rz_xc_r - rz_ys_r;
      rc_y_r <= rz_yc_r + rz_xs_r;
      rc_z_r <= rz_z_r;
      rc_d_r <= rz_d_r;
    end
    if (ld[OUT_ST]) begin
      out_r.out_x <= sat_coord(rc_x_r + rc_d_r);
      out_r.out_y <= sat_coord(rc_y_r);
      out_r.out_z <= sat_coord(rc_z_r);
    end
  end

endmodule

`default_nettype wire

// ===== src/eulxyz_chk.sv =====
// Port-level checker for the Euler x-y-z rotate block, bound to the top level.
// Depends on eulxyz_pkg and euler_xyz_rotate_translate_top.
`timescale 1ns / 1ps
`default_nettype none

module eulxyz_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input eulxyz_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input eulxyz_pkg::out_item_t out_data
);
  import eulxyz_pkg::*;

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result transfer changed or dropped");

  a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("stalled input transfer changed or dropped");

endmodule

bind euler_xyz_rotate_translate_top eulxyz_chk u_chk (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for euler_xyz_rotate_translate_top: directed and random points through the pipeline.
// Depends on eulxyz_pkg; a scoreboard class predicts each transfer with its own fixed-point math.
`timescale 1ns / 1ps

module tb;
  import eulxyz_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  localparam int     N_RANDOM = 735;
  localparam longint Q30      = longint'(1) << 30;
  localparam longint HALF_Q30 = longint'(1) << 29;
  localparam longint HP       = 64'd1686629713;

  class rotation_scoreboard;
    out_item_t expected_points[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    static function longint scale_q30(longint a, longint t);
      bit        neg;
      bit [63:0] ma;
      bit [63:0] mt;
      bit [63:0] r;
      neg = (a < 0) != (t < 0);
      ma  = (a < 0) ? -a : a;
      mt  = (t < 0) ? -t : t;
      r   = (ma >> 30) * mt + (((ma & (Q30 - 1)) * mt + HALF_Q30) >> 30);
      return neg ? -longint'(r) : longint'(r);
    endfunction

    static function longint series(longint u2, int first_k, bit odd);
      longint s;
      longint d;
      longint p;
      s = Q30;
      for (int k = first_k; k >= 1; k--) begin
        d = odd ? longint'(2 * k) * (2 * k + 1) : longint'(2 * k - 1) * (2 * k);
        p = (u2 * s + HALF_Q30) >>> 30;
        s = Q30 - (p + d / 2) / d;
      end
      return s;
    endfunction

    static function void trig(angle_t ang, output longint sn, output longint cs);
      logic [31:0] t;
      longint      u;
      longint      u2;
      longint      s;
      longint      c;
      quad_t       q;
      t  = {ang, {(32 - ANGLE_WIDTH){1'b0}}};
      q  = quad_t'(t[31:30]);
      u  = (longint'(t[29:0]) * HP + HALF_Q30) >>> 30;
      u2 = (u * u + HALF_Q30) >>> 30;
      s  = (u * series(u2, 8, 1'b1) + HALF_Q30) >>> 30;
      c  = series(u2, 9, 1'b0);
      case (q)
        QUAD_0: begin sn = s;  cs = c;  end
        QUAD_1: begin sn = c;  cs = -s; end
        QUAD_2: begin sn = -s; cs = -c; end
        default: begin sn = -c; cs = s; end
      endcase
    endfunction

    static function coord_t clamp(longint v);
      if (v > 64'sd2147483647) return coord_t'(32'h7fff_ffff);
      if (v < -64'sd2147483648) return coord_t'(32'h8000_0000);
      return coord_t'(v);
    endfunction

    function void note_input(in_item_t it);
      longint x, y, z, s, c, a, b;
      out_item_t r;
      x = it.vec_x;
      y = it.vec_y;
      z = it.vec_z;
      trig(it.angle_x, s, c);
      a = scale_q30(y, c) - scale_q30(z, s);
      b = scale_q30(y, s) + scale_q30(z, c);
      y = a; z = b;
      trig(it.angle_y, s, c);
      a = scale_q30(x, c) + scale_q30(z, s);
      b = scale_q30(z, c) - scale_q30(x, s);
      x = a; z = b;
      trig(it.angle_z, s, c);
      a = scale_q30(x, c) - scale_q30(y, s);
      b = scale_q30(y, c) + scale_q30(x, s);
      x = a; y = b;
      r.out_x = clamp(x + longint'(it.offset_d));
      r.out_y = clamp(y);
      r.out_z = clamp(z);
      expected_points.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_points.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", got.out_x, got.out_y, got.out_z);
        errors++;
        return;
      end
      e = expected_points.pop_front();
      if (got.out_x !== e.out_x) begin
        $error("out_x expected %0d actual %0d", e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== e.out_y) begin
        $error("out_y expected %0d actual %0d", e.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== e.out_z) begin
        $error("out_z expected %0d actual %0d", e.out_z, got.out_z);
        errors++;
      end
    endfunction
  endclass

  rotation_scoreboard sb = new();

  euler_xyz_rotate_translate_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic int draw_gap(int n);
    if ((n / 60) % 3 == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(32'h7fff_ffff);
      1: return coord_t'(32'h8000_0000);
      2: return coord_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 4))
      0: return angle_t'($urandom_range(0, 3) * 16'h4000);
      1: return angle_t'(16'hffff);
      default: return angle_t'($urandom);
    endcase
  endfunction

  task automatic send_point(in_item_t it, int n);
    int gap;
    gap = draw_gap(n);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  function automatic in_item_t make_point(coord_t x, coord_t y, coord_t z,
                                          angle_t ax, angle_t ay, angle_t az, coord_t d);
    in_item_t it;
    it.vec_x = x; it.vec_y = y; it.vec_z = z;
    it.angle_x = ax; it.angle_y = ay; it.angle_z = az;
    it.offset_d = d;
    return it;
  endfunction

  initial begin
    int gap;
    int n;
    out_ready = 1'b0;
    n = 0;
    @(posedge rst_n);
    forever begin
      gap = (n == 120) ? 300 : draw_gap(n + 30);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      n++;
    end
  end

  initial begin
    coord_t mx, mn;
    int     wait_cycles;
    mx = coord_t'(32'h7fff_ffff);
    mn = coord_t'(32'h8000_0000);
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_point(make_point(0, 0, 0, 0, 0, 0, 0), 0);
    send_point(make_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0, 0), 0);
    send_point(make_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                          16'h4000, 0, 0, 0), 0);
    send_point(make_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                          0, 16'h8000, 0, 0), 0);
    send_point(make_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                          0, 0, 16'hc000, 0), 0);
    send_point(make_point(32'sh0001_0000, -32'sh0002_0000, 32'sh0003_0000,
                          16'h0001, 16'hffff, 16'h2000, 32'sh0001_8000), 0);
    send_point(make_point(mx, mx, mx, 0, 0, 0, 0), 0);
    send_point(make_point(mn, mn, mn, 0, 0, 0, 0), 0);
    send_point(make_point(mx, 0, 0, 0, 0, 0, mx), 0);
    send_point(make_point(mn, 0, 0, 0, 0, 0, mn), 0);
    send_point(make_point(mx, mn, mx, 16'h2000, 16'h2000, 16'h2000, mx), 0);
    send_point(make_point(mn, mx, mn, 16'he000, 16'h6000, 16'ha000, mn), 0);
    send_point(make_point(mx, mx, mn, 16'hffff, 16'hffff, 16'hffff, 0), 0);
    send_point(make_point(-1, 1, -1, 16'h8000, 16'hc000, 16'h4000, -1), 0);
    send_point(make_point(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f,
                          16'h5555, 16'haaaa, 16'h0f0f, 32'shf0f0_f0f0), 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      send_point(make_point(rand_coord(), rand_coord(), rand_coord(),
                            rand_angle(), rand_angle(), rand_angle(), rand_coord()), i);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.expected_points.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (sb.expected_points.size() != 0) begin
      $error("%0d results never arrived", sb.expected_points.size());
      sb.errors++;
    end
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** euler_xyz_rotate_translate_top: PASSED **");
    end else begin
      $display("** euler_xyz_rotate_translate_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** euler_xyz_rotate_translate_top: FAILED **");
    $finish;
  end

endmodule
